>>> design/dlg_pkg.sv
// ----------------------------------------------------------------------------
// dlg_pkg
// Shared types, constants and elaboration-time table functions for the
// Dice loss and gradient block.
// ----------------------------------------------------------------------------
package dlg_pkg;

	localparam int unsigned DEF_MAX_ELEMENTS = 1048576;
	localparam int unsigned DEF_TABLE_DEPTH = 1024;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [16:0] ONE_Q15 = 17'd32768;

	// Input operation codes.
	localparam logic OP_FORWARD = 1'b0;
	localparam logic OP_GRADIENT = 1'b1;

	// Result kinds.
	localparam logic KIND_LOSS = 1'b0;
	localparam logic KIND_GRADIENT = 1'b1;

	// One classified item as it travels from the front to the back.
	typedef struct packed {
		logic opcode;
		logic [15:0] prob;
		logic [15:0] target;
		logic [31:0] upstream;
		logic last;
	} dlg_item_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic empty;
	} dlg_qstat_t;

	// Restoring division, used only while the sigmoid constants are built.
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Sigmoid table entry k for a table of the given depth, Q1.15.
	function automatic logic [15:0] sigmoid_entry(input int unsigned k,
			input int unsigned depth);
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] step;
		logic [63:0] c;
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] den;
		logic [63:0] p;
		logic [16:0] m;
		int x;
		term = 64'd1 << 40;
		sum = term;
		for (int n = 1; n <= 6; n++) begin
			term = udiv64(term, 64'(256 * n));
			if ((n & 1) != 0) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		step = (sum + (64'd1 << 9)) >> 10;
		c = udiv64(64'(2 * k + 1) * 64'd32768, 64'(depth));
		x = int'(c) - 32768;
		m = 17'((x < 0) ? -x : x);
		r = 64'd1 << 30;
		b = step;
		for (int i = 0; i < 17; i++) begin
			if (m[i]) begin
				r = (r * b + (64'd1 << 29)) >> 30;
			end
			b = (b * b + (64'd1 << 29)) >> 30;
		end
		den = (64'd1 << 30) + r;
		if (x >= 0) begin
			p = udiv64((64'd1 << 45) + (den >> 1), den);
		end else begin
			p = udiv64((r << 15) + (den >> 1), den);
		end
		return p[15:0];
	endfunction

endpackage

>>> design/dlg_front.sv
// ----------------------------------------------------------------------------
// dlg_front
// Accepts input items, clamps the target and looks up the sigmoid of the
// logit in a constant table; holds one classified item for the queue.
// ----------------------------------------------------------------------------
module dlg_front #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic opcode,
	input logic signed [15:0] logit,
	input logic [15:0] target,
	input logic signed [31:0] upstream_gradient,
	input logic last_element,
	input dlg_pkg::dlg_qstat_t qstat,
	output logic item_valid,
	output dlg_pkg::dlg_item_t item
);
	import dlg_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int PW = 17 + IW;

	logic [15:0] rom [TABLE_DEPTH];
	logic [15:0] biased;
	logic [PW-1:0] prod;
	logic [IW-1:0] idx;
	logic [15:0] target_clamped;
	logic accept;
	logic valid_s1;
	dlg_item_t item_s1;

	// Constant sigmoid table, one entry per logit bucket.
	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_rom
		localparam logic [15:0] ENTRY = sigmoid_entry(k, TABLE_DEPTH);
		assign rom[k] = ENTRY;
	end

	// The biased logit selects the table bucket.
	assign biased = {~logit[15], logit[14:0]};
	assign prod = PW'(biased) * PW'(TABLE_DEPTH);
	assign idx = prod[16 +: IW];
	assign target_clamped = (target > ONE_Q15[15:0]) ? ONE_Q15[15:0] : target;

	assign in_stall = valid_s1 && qstat.full;
	assign accept = in_valid && !in_stall;

	// The held item leaves whenever the queue has room.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!qstat.full) begin
			valid_s1 <= 1'b0;
		end
	end

	// Registered table read together with the rest of the item.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.opcode <= opcode;
			item_s1.prob <= rom[idx];
			item_s1.target <= target_clamped;
			item_s1.upstream <= upstream_gradient;
			item_s1.last <= last_element;
		end
	end

	assign item_valid = valid_s1;
	assign item = item_s1;

endmodule

>>> design/dlg_queue.sv
// ----------------------------------------------------------------------------
// dlg_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module dlg_queue (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	input dlg_pkg::dlg_item_t push_item,
	input logic pop,
	output dlg_pkg::dlg_item_t head_item,
	output dlg_pkg::dlg_qstat_t qstat
);
	import dlg_pkg::*;

	localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	dlg_item_t mem [QUEUE_DEPTH];
	logic [PTRW-1:0] wr_ptr_q;
	logic [PTRW-1:0] rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic push;
	logic do_pop;

	assign qstat.full = (count_q == CNTW'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign push = push_valid && !qstat.full;
	assign do_pop = pop && !qstat.empty;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	assign head_item = mem[rd_ptr_q];

endmodule

>>> design/dlg_divider.sv
// ----------------------------------------------------------------------------
// dlg_divider
// Restoring divider, one quotient bit per cycle, 64-bit dividend by a
// 38-bit divisor.
// ----------------------------------------------------------------------------
module dlg_divider (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] dividend,
	input logic [37:0] divisor,
	output logic done,
	output logic [63:0] quotient
);
	import dlg_pkg::*;

	logic busy_q;
	logic done_q;
	logic [5:0] cnt_q;
	logic [37:0] rem_q;
	logic [37:0] den_q;
	logic [63:0] num_q;
	logic [38:0] trial;
	logic fits;

	assign trial = {rem_q, num_q[63]};
	assign fits = (trial >= {1'b0, den_q});

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == 6'd63);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Quotient bits shift in where the dividend bits leave.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			num_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? 38'(trial - {1'b0, den_q}) : trial[37:0];
			num_q <= {num_q[62:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = num_q;

endmodule

>>> design/dlg_back.sv
// ----------------------------------------------------------------------------
// dlg_back
// Carries out queued items: accumulates forward items, closes a pass with
// the loss, and computes gradients from the frozen sums.
// ----------------------------------------------------------------------------
module dlg_back #(
	parameter int unsigned MAX_ELEMENTS = 1048576
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write_enable,
	input logic [15:0] cfg_write_data,
	input dlg_pkg::dlg_item_t head_item,
	input dlg_pkg::dlg_qstat_t qstat,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output logic result_kind,
	output logic [15:0] loss_value,
	output logic signed [31:0] gradient_value
);
	import dlg_pkg::*;

	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam logic [35:0] ACC_LIMIT = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_F_MUL,
		ST_F_ACC,
		ST_F_DIV,
		ST_G_MUL1,
		ST_G_MUL2,
		ST_G_START,
		ST_G_DIV,
		ST_G_LO,
		ST_G_HI,
		ST_G_SUM,
		ST_OUT
	} state_t;

	state_t state_q;
	dlg_item_t item_q;
	logic [15:0] eps_q;
	logic [35:0] acc_i_q;
	logic [35:0] acc_p_q;
	logic [35:0] acc_t_q;
	logic [CW-1:0] cnt_q;
	logic [37:0] frozen_u_q;
	logic [16:0] frozen_q_q;
	logic [31:0] py_q;
	logic [31:0] s_q;
	logic a_neg_q;
	logic [16:0] a_mag_q;
	logic g_neg_q;
	logic [31:0] gmag_q;
	logic [48:0] as_q;
	logic [63:0] w_q;
	logic [63:0] plo_q;
	logic [63:0] phi_q;
	logic div_start_q;
	logic [63:0] div_num_q;
	logic [37:0] div_den_q;
	logic res_kind_q;
	logic [15:0] res_loss_q;
	logic [31:0] res_grad_q;
	logic out_valid_q;
	logic out_kind_q;
	logic [15:0] out_loss_q;
	logic [31:0] out_grad_q;

	logic div_done;
	logic [63:0] div_quo;

	logic inc;
	logic [16:0] pyr;
	logic [36:0] i_sum;
	logic [36:0] p_sum;
	logic [36:0] t_sum;
	logic [35:0] i_next;
	logic [35:0] p_next;
	logic [35:0] t_next;
	logic [37:0] u_next;
	logic [37:0] d_next;
	logic [16:0] dice;
	logic [18:0] a_val;
	logic [95:0] total;
	logic [49:0] mag;
	logic neg;
	logic [31:0] grad_sat;

	dlg_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start_q),
		.dividend(div_num_q),
		.divisor(div_den_q),
		.done(div_done),
		.quotient(div_quo)
	);

	assign pop = (state_q == ST_IDLE) && !qstat.empty;

	// Saturating accumulation and the sums that close a pass.
	assign inc = (cnt_q < CW'(MAX_ELEMENTS));
	assign pyr = 17'((33'(py_q) + 33'd16384) >> 15);
	assign i_sum = {1'b0, acc_i_q} + 37'(pyr);
	assign p_sum = {1'b0, acc_p_q} + 37'(item_q.prob);
	assign t_sum = {1'b0, acc_t_q} + 37'(item_q.target);
	assign i_next = !inc ? acc_i_q : (i_sum > 37'(ACC_LIMIT)) ? ACC_LIMIT : i_sum[35:0];
	assign p_next = !inc ? acc_p_q : (p_sum > 37'(ACC_LIMIT)) ? ACC_LIMIT : p_sum[35:0];
	assign t_next = !inc ? acc_t_q : (t_sum > 37'(ACC_LIMIT)) ? ACC_LIMIT : t_sum[35:0];
	assign u_next = 38'(p_next) + 38'(t_next) + 38'(eps_q);
	assign d_next = {1'b0, i_next, 1'b0} + 38'(eps_q);

	// Ratio clamped to one.
	assign dice = (div_quo > 64'(ONE_Q15)) ? ONE_Q15 : div_quo[16:0];

	// Signed factor 2y - q.
	assign a_val = {2'b00, item_q.target, 1'b0} - {2'b00, frozen_q_q};

	// Rounded product of the weight and the upstream magnitude, saturated.
	assign total = {phi_q, 32'd0} + 96'(plo_q) + (96'd1 << 45);
	assign mag = total[95:46];
	assign neg = (a_neg_q == g_neg_q);
	always_comb begin
		if (mag == '0) begin
			grad_sat = '0;
		end else if (neg) begin
			grad_sat = (mag > 50'h80000000) ? 32'h80000000 : (~mag[31:0] + 32'd1);
		end else begin
			grad_sat = (mag > 50'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
		end
	end

	// Sequencer with all registered state and results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			item_q <= '0;
			eps_q <= 16'd32768;
			acc_i_q <= '0;
			acc_p_q <= '0;
			acc_t_q <= '0;
			cnt_q <= '0;
			frozen_u_q <= '0;
			frozen_q_q <= '0;
			py_q <= '0;
			s_q <= '0;
			a_neg_q <= 1'b0;
			a_mag_q <= '0;
			g_neg_q <= 1'b0;
			gmag_q <= '0;
			as_q <= '0;
			w_q <= '0;
			plo_q <= '0;
			phi_q <= '0;
			div_start_q <= 1'b0;
			div_num_q <= '0;
			div_den_q <= '0;
			res_kind_q <= KIND_LOSS;
			res_loss_q <= '0;
			res_grad_q <= '0;
			out_valid_q <= 1'b0;
			out_kind_q <= KIND_LOSS;
			out_loss_q <= '0;
			out_grad_q <= '0;
		end else begin
			// The divider starts after a closing forward item or a gradient setup.
			div_start_q <= ((state_q == ST_F_ACC) && item_q.last && (u_next != '0))
				|| (state_q == ST_G_START);
			if (cfg_write_enable) begin
				eps_q <= cfg_write_data;
			end
			if (out_valid_q && !out_stall && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!qstat.empty) begin
						item_q <= head_item;
						state_q <= (head_item.opcode == OP_GRADIENT) ? ST_G_MUL1 : ST_F_MUL;
					end
				end
				ST_F_MUL: begin
					py_q <= item_q.prob * item_q.target;
					state_q <= ST_F_ACC;
				end
				ST_F_ACC: begin
					if (item_q.last) begin
						frozen_u_q <= u_next;
						acc_i_q <= '0;
						acc_p_q <= '0;
						acc_t_q <= '0;
						cnt_q <= '0;
						res_kind_q <= KIND_LOSS;
						res_grad_q <= '0;
						if (u_next == '0) begin
							frozen_q_q <= ONE_Q15;
							res_loss_q <= '0;
							state_q <= ST_OUT;
						end else begin
							div_num_q <= 64'({d_next, 15'd0}) + 64'(u_next >> 1);
							div_den_q <= u_next;
							state_q <= ST_F_DIV;
						end
					end else begin
						acc_i_q <= i_next;
						acc_p_q <= p_next;
						acc_t_q <= t_next;
						cnt_q <= cnt_q + CW'(inc);
						state_q <= ST_IDLE;
					end
				end
				ST_F_DIV: begin
					if (div_done) begin
						frozen_q_q <= dice;
						res_loss_q <= 16'(ONE_Q15 - dice);
						state_q <= ST_OUT;
					end
				end
				ST_G_MUL1: begin
					res_kind_q <= KIND_GRADIENT;
					res_loss_q <= '0;
					if (frozen_u_q == '0) begin
						res_grad_q <= '0;
						state_q <= ST_OUT;
					end else begin
						s_q <= item_q.prob * 16'(ONE_Q15 - 17'(item_q.prob));
						a_neg_q <= a_val[18];
						a_mag_q <= a_val[18] ? 17'(-a_val) : a_val[16:0];
						g_neg_q <= item_q.upstream[31];
						gmag_q <= item_q.upstream[31] ? (~item_q.upstream + 32'd1)
							: item_q.upstream;
						state_q <= ST_G_MUL2;
					end
				end
				ST_G_MUL2: begin
					as_q <= a_mag_q * s_q;
					state_q <= ST_G_START;
				end
				ST_G_START: begin
					div_num_q <= 64'({as_q, 16'd0}) + 64'(frozen_u_q >> 1);
					div_den_q <= frozen_u_q;
					state_q <= ST_G_DIV;
				end
				ST_G_DIV: begin
					if (div_done) begin
						w_q <= div_quo;
						state_q <= ST_G_LO;
					end
				end
				ST_G_LO: begin
					plo_q <= w_q[31:0] * gmag_q;
					state_q <= ST_G_HI;
				end
				ST_G_HI: begin
					phi_q <= w_q[63:32] * gmag_q;
					state_q <= ST_G_SUM;
				end
				ST_G_SUM: begin
					res_grad_q <= grad_sat;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_kind_q <= res_kind_q;
						out_loss_q <= res_loss_q;
						out_grad_q <= res_grad_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign result_kind = out_kind_q;
	assign loss_value = out_loss_q;
	assign gradient_value = out_grad_q;

endmodule

>>> design/dice_loss_and_gradient.sv
// ----------------------------------------------------------------------------
// dice_loss_and_gradient
// Soft Dice loss with a table sigmoid, and its per-element gradient.
// ----------------------------------------------------------------------------
// Items enter a front stage that clamps the target and reads the sigmoid
// table, then wait in a two-entry queue for the back sequencer, which works
// on one item at a time. A forward item without the last mark goes through
// the back steps dequeue, multiply and accumulate. The item that closes a
// pass with a nonzero union, and every gradient item while the frozen union
// is nonzero, run the shared restoring divider, one quotient bit per cycle.
// A gradient with a zero frozen union, as before any closed pass, returns
// zero. The eps register may be written only while the block is idle.
// ----------------------------------------------------------------------------
module dice_loss_and_gradient #(
	parameter int unsigned MAX_ELEMENTS = dlg_pkg::DEF_MAX_ELEMENTS,
	parameter int unsigned SIGMOID_TABLE_DEPTH = dlg_pkg::DEF_TABLE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write_enable,
	input logic [15:0] cfg_write_data,
	input logic in_valid,
	output logic in_stall,
	input logic opcode,
	input logic signed [15:0] logit,
	input logic [15:0] target,
	input logic signed [31:0] upstream_gradient,
	input logic last_element,
	output logic out_valid,
	input logic out_stall,
	output logic result_kind,
	output logic [15:0] loss_value,
	output logic signed [31:0] gradient_value
);
	import dlg_pkg::*;

	logic front_valid;
	dlg_item_t front_item;
	dlg_item_t head_item;
	dlg_qstat_t qstat;
	logic pop;

	// Front: accept and classify.
	dlg_front #(
		.TABLE_DEPTH(SIGMOID_TABLE_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.logit(logit),
		.target(target),
		.upstream_gradient(upstream_gradient),
		.last_element(last_element),
		.qstat(qstat),
		.item_valid(front_valid),
		.item(front_item)
	);

	// Queue between front and back.
	dlg_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(front_valid),
		.push_item(front_item),
		.pop(pop),
		.head_item(head_item),
		.qstat(qstat)
	);

	// Back: accumulate, close passes, compute gradients.
	dlg_back #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_enable(cfg_write_enable),
		.cfg_write_data(cfg_write_data),
		.head_item(head_item),
		.qstat(qstat),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.loss_value(loss_value),
		.gradient_value(gradient_value)
	);

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Dice loss and gradient block. A directed table
// covers extremes and corner cases, then random passes run under three idle
// profiles. Each accepted result is checked by a predictor or a fixed row.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dlg_pkg::*;

	localparam int unsigned TABLE_DEPTH = 1024;
	localparam int unsigned ELEMENT_LIMIT = 1048576;
	localparam longint unsigned SUM_LIMIT = (64'd1 << 36) - 64'd1;
	localparam int DRAIN_CYCLES = 120;

	typedef struct {
		logic kind;
		logic [15:0] loss;
		logic [31:0] grad;
	} dice_result_t;

	typedef struct {
		logic op;
		logic [15:0] logit;
		logic [15:0] target;
		logic [31:0] upstream;
		logic last;
		int eps_write;
		bit fixed_result;
		dice_result_t result;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_enable = 1'b0;
	logic [15:0] cfg_write_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = 1'b0;
	logic signed [15:0] logit = '0;
	logic [15:0] target = '0;
	logic signed [31:0] upstream_gradient = '0;
	logic last_element = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic result_kind;
	logic [15:0] loss_value;
	logic signed [31:0] gradient_value;

	dice_loss_and_gradient u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_enable(cfg_write_enable),
		.cfg_write_data(cfg_write_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.logit(logit),
		.target(target),
		.upstream_gradient(upstream_gradient),
		.last_element(last_element),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.loss_value(loss_value),
		.gradient_value(gradient_value)
	);

	// Predictor state.
	logic [15:0] prob_lut [TABLE_DEPTH];
	longint unsigned inter_acc, prob_acc, targ_acc;
	longint unsigned union_frozen, numer_frozen;
	int unsigned pass_count;
	longint unsigned eps_reg;

	dice_result_t pending_results[$];
	stim_row_t directed_rows[$];
	int error_count = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int hold_cycles = 0;

	// Clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit.
	initial begin
		#20ms;
		$display("dice_loss_and_gradient test failed");
		$finish;
	end

	function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
		return (a * b + (64'd1 << 29)) >> 30;
	endfunction

	// Sigmoid constants, Q1.15, from a series for e^(-1/256).
	task automatic build_prob_lut();
		longint unsigned term, sum, step, e, base, den;
		int x;
		int unsigned m;
		term = 64'd1 << 40;
		sum = term;
		for (int n = 1; n <= 6; n++) begin
			term = term / (256 * n);
			if (n % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		step = (sum + (64'd1 << 9)) >> 10;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			x = int'(((2 * k + 1) * 32768) / TABLE_DEPTH) - 32768;
			m = (x < 0) ? -x : x;
			e = 64'd1 << 30;
			base = step;
			while (m != 0) begin
				if (m[0]) begin
					e = q30_mul(e, base);
				end
				base = q30_mul(base, base);
				m = m >> 1;
			end
			den = (64'd1 << 30) + e;
			if (x >= 0) begin
				prob_lut[k] = 16'(((64'd1 << 45) + den / 2) / den);
			end else begin
				prob_lut[k] = 16'(((e << 15) + den / 2) / den);
			end
		end
	endtask

	function automatic longint unsigned sat_sum(longint unsigned acc, longint unsigned v);
		return (acc + v > SUM_LIMIT) ? SUM_LIMIT : acc + v;
	endfunction

	function automatic longint unsigned q15_ratio(longint unsigned num, longint unsigned den);
		longint unsigned r;
		r = ((num << 15) + den / 2) / den;
		return (r > 32768) ? 64'd32768 : r;
	endfunction

	// Works out the result of one accepted item and updates the sums.
	task automatic predict_dice(input logic op, input logic [15:0] lg, input logic [15:0] tg,
			input logic [31:0] ug, input logic lst, output bit has, output dice_result_t r);
		longint unsigned p, y, u, d, dice, q, a_mag, g_mag, w, mag;
		longint signed a;
		logic [127:0] prod;
		bit a_neg, g_neg;
		p = prob_lut[(lg ^ 16'h8000) >> 6];
		y = (tg > 16'd32768) ? 64'd32768 : 64'(tg);
		has = 1'b0;
		r = '{KIND_LOSS, 16'd0, 32'd0};
		if (op == OP_FORWARD) begin
			if (pass_count < ELEMENT_LIMIT) begin
				inter_acc = sat_sum(inter_acc, (p * y + 16384) >> 15);
				prob_acc = sat_sum(prob_acc, p);
				targ_acc = sat_sum(targ_acc, y);
				pass_count++;
			end
			if (lst) begin
				u = prob_acc + targ_acc + eps_reg;
				d = 2 * inter_acc + eps_reg;
				dice = (u == 0) ? 64'd32768 : q15_ratio(d, u);
				union_frozen = u;
				numer_frozen = d;
				inter_acc = 0;
				prob_acc = 0;
				targ_acc = 0;
				pass_count = 0;
				has = 1'b1;
				r.loss = 16'(64'd32768 - dice);
			end
		end else begin
			has = 1'b1;
			r.kind = KIND_GRADIENT;
			if (union_frozen != 0) begin
				q = q15_ratio(numer_frozen, union_frozen);
				a = longint'(2 * y) - longint'(q);
				a_neg = a < 0;
				a_mag = a_neg ? -a : a;
				g_neg = ug[31];
				g_mag = g_neg ? 64'(32'(-ug)) : 64'(ug);
				w = (((a_mag * (p * (32768 - p))) << 16) + union_frozen / 2) / union_frozen;
				prod = (128'(w) * 128'(g_mag) + (128'd1 << 45)) >> 46;
				mag = 64'(prod);
				if (mag != 0) begin
					if (a_neg == g_neg) begin
						r.grad = (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
					end else begin
						r.grad = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(mag);
					end
				end
			end
		end
	endtask

	// Offers one item, waits for acceptance and records its expectation.
	task automatic send_item(input logic op, input logic [15:0] lg, input logic [15:0] tg,
			input logic [31:0] ug, input logic lst, input bit fixed, input dice_result_t fr);
		bit has;
		dice_result_t r;
		in_valid <= 1'b1;
		opcode <= op;
		logit <= lg;
		target <= tg;
		upstream_gradient <= ug;
		last_element <= lst;
		do begin
			@(posedge clk);
		end while (in_stall);
		predict_dice(op, lg, tg, ug, lst, has, r);
		if (has) begin
			pending_results.push_back(fixed ? fr : r);
		end
		if ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Stops offering items until every result is in, then lets the block settle.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_eps(input logic [15:0] v);
		cfg_write_enable <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_enable <= 1'b0;
		eps_reg = v;
	endtask

	function automatic void add_row(logic op, logic [15:0] lg, logic [15:0] tg,
			logic [31:0] ug, logic lst, int eps_write, bit fixed, dice_result_t r);
		stim_row_t row;
		row = '{op, lg, tg, ug, lst, eps_write, fixed, r};
		directed_rows.push_back(row);
	endfunction

	function automatic logic [15:0] rand_target();
		return ($urandom_range(9) == 0) ? 16'($urandom_range(65535)) :
			16'($urandom_range(32768));
	endfunction

	function automatic logic [31:0] rand_upstream();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($signed(16'($urandom)));
			default: return 32'($urandom);
		endcase
	endfunction

	// Random passes: mostly a well-formed pass followed by gradient items.
	task automatic random_phase(input int items);
		int sent, len;
		dice_result_t none;
		none = '{KIND_LOSS, 16'd0, 32'd0};
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(7) == 0) begin
				// Noise: any opcode, any mark.
				send_item(1'($urandom), 16'($urandom), rand_target(), rand_upstream(),
					1'($urandom), 1'b0, none);
				sent++;
			end else begin
				len = ($urandom_range(15) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(15) == 0) begin
						send_item(OP_GRADIENT, 16'($urandom), rand_target(),
							rand_upstream(), 1'($urandom), 1'b0, none);
						sent++;
					end
					send_item(OP_FORWARD, 16'($urandom), rand_target(), 32'($urandom),
						i == len - 1, 1'b0, none);
					sent++;
				end
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					send_item(OP_GRADIENT, 16'($urandom), rand_target(), rand_upstream(),
						1'($urandom), 1'b0, none);
					sent++;
				end
			end
		end
	endtask

	// Receiver: random stall, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		dice_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%t: result with nothing expected: kind %0d loss %0d grad %0d",
					$time, result_kind, loss_value, gradient_value);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (result_kind !== exp_r.kind) begin
					$display("%t: result_kind expected %0d actual %0d",
						$time, exp_r.kind, result_kind);
					error_count++;
				end
				if (loss_value !== exp_r.loss) begin
					$display("%t: loss_value expected %0d actual %0d",
						$time, exp_r.loss, loss_value);
					error_count++;
				end
				if (gradient_value !== exp_r.grad) begin
					$display("%t: gradient_value expected %0d actual %0d",
						$time, $signed(exp_r.grad), gradient_value);
					error_count++;
				end
			end
		end
	end

	// Main sequence.
	initial begin
		dice_result_t none;
		dice_result_t zero_grad;
		dice_result_t zero_loss;
		none = '{KIND_LOSS, 16'd0, 32'd0};
		zero_grad = '{KIND_GRADIENT, 16'd0, 32'd0};
		zero_loss = '{KIND_LOSS, 16'd0, 32'd0};
		build_prob_lut();
		inter_acc = 0;
		prob_acc = 0;
		targ_acc = 0;
		union_frozen = 0;
		numer_frozen = 0;
		pass_count = 0;
		eps_reg = 32768;

		// Gradient before any pass is closed gives zero.
		add_row(OP_GRADIENT, 16'h0000, 16'd0, 32'h0100_0000, 1'b0, -1, 1'b1, zero_grad);
		add_row(OP_FORWARD, 16'h8000, 16'd0, 32'd0, 1'b1, -1, 1'b0, none);
		add_row(OP_FORWARD, 16'h7FFF, 16'd32768, 32'd0, 1'b0, -1, 1'b0, none);
		// Target above one is clamped.
		add_row(OP_FORWARD, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, -1, 1'b0, none);
		add_row(OP_FORWARD, 16'hFFFF, 16'd16384, 32'd0, 1'b1, -1, 1'b0, none);
		add_row(OP_GRADIENT, 16'h0000, 16'd32768, 32'h7FFF_FFFF, 1'b1, -1, 1'b0, none);
		add_row(OP_GRADIENT, 16'h0000, 16'd0, 32'h8000_0000, 1'b0, -1, 1'b0, none);
		add_row(OP_GRADIENT, 16'h7FFF, 16'hFFFF, 32'd0, 1'b0, -1, 1'b0, none);
		add_row(OP_GRADIENT, 16'h8000, 16'd16384, 32'hFFFF_FFFF, 1'b0, -1, 1'b0, none);
		add_row(OP_GRADIENT, 16'h0100, 16'd0, 32'h0100_0000, 1'b0, -1, 1'b0, none);
		add_row(OP_GRADIENT, 16'h5555, 16'hAAAA, 32'h5555_AAAA, 1'b1, -1, 1'b0, none);
		// Empty union with eps zero: dice is one and the gradient is zero.
		add_row(OP_FORWARD, 16'h8000, 16'd0, 32'd0, 1'b1, 0, 1'b1, zero_loss);
		add_row(OP_GRADIENT, 16'h0064, 16'd32768, 32'h0100_0000, 1'b0, -1, 1'b1, zero_grad);
		add_row(OP_FORWARD, 16'h7FFF, 16'd32768, 32'd0, 1'b1, 65535, 1'b0, none);
		add_row(OP_FORWARD, 16'h0000, 16'd0, 32'd0, 1'b1, -1, 1'b0, none);
		add_row(OP_GRADIENT, 16'h0000, 16'hFFFF, 32'h7FFF_FFFF, 1'b0, -1, 1'b0, none);
		add_row(OP_GRADIENT, 16'hFF00, 16'd0, 32'h8000_0001, 1'b0, -1, 1'b0, none);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed table.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].eps_write >= 0) begin
				drain_results();
				write_eps(16'(directed_rows[i].eps_write));
			end
			send_item(directed_rows[i].op, directed_rows[i].logit, directed_rows[i].target,
				directed_rows[i].upstream, directed_rows[i].last,
				directed_rows[i].fixed_result, directed_rows[i].result);
		end

		// Sender idles lightly, receiver heavily.
		drain_results();
		write_eps(16'($urandom));
		snd_idle_pct = 12;
		rcv_idle_pct = 51;
		random_phase(280);
		drain_results();
		write_eps(16'd0);
		random_phase(280);

		// The other way round.
		drain_results();
		write_eps(16'd65535);
		snd_idle_pct = 51;
		rcv_idle_pct = 12;
		random_phase(280);
		drain_results();
		write_eps(16'($urandom));
		random_phase(280);

		// No idling, with a long receiver hold-off while items keep coming.
		drain_results();
		write_eps(16'd32768);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		send_item(OP_FORWARD, 16'($urandom), rand_target(), 32'd0, 1'b1, 1'b0, none);
		hold_cycles = 400;
		for (int i = 0; i < 12; i++) begin
			send_item(OP_GRADIENT, 16'($urandom), rand_target(), rand_upstream(), 1'b0,
				1'b0, none);
		end
		random_phase(280);
		drain_results();
		write_eps(16'($urandom));
		random_phase(280);

		drain_results();
		if (error_count == 0) begin
			$display("dice_loss_and_gradient test passed");
		end else begin
			$display("dice_loss_and_gradient test failed");
		end
		$finish;
	end

endmodule
